// ===== sv/swdseq_pkg.sv =====
// Shared types, codes and a helper function for the SWD access sequencer.
package swdseq_pkg;

  localparam int unsigned CFG_IDX_W  = 1;
  localparam int unsigned CFG_DATA_W = 10;
  localparam int unsigned TRIES_W    = 10;

  localparam logic [CFG_IDX_W-1:0] CFG_ALLOW_TIMEOUT = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_TRIES     = 1'b1;

  localparam logic [TRIES_W-1:0] MAX_TRIES_RESET = 10'd1000;

  localparam logic [2:0] ACK_OK    = 3'h1;
  localparam logic [2:0] ACK_WAIT  = 3'h2;
  localparam logic [2:0] ACK_FAULT = 3'h4;

  localparam logic [7:0] REQ_BASE     = 8'h81;
  localparam logic [7:0] REQ_AP_FLIP  = 8'h22;
  localparam logic [7:0] REQ_RD_FLIP  = 8'h24;
  localparam logic [7:0] REQ_PAR_FLIP = 8'h20;
  localparam logic [3:0] ADDR_MASK    = 4'hC;
  localparam logic [3:0] ADDR_4       = 4'h4;
  localparam logic [3:0] ADDR_8       = 4'h8;

  typedef enum logic [1:0] {
    CMD_START = 2'd0,
    CMD_ACK   = 2'd1,
    CMD_RDATA = 2'd2,
    CMD_CLEAR = 2'd3
  } cmd_t;

  typedef enum logic [2:0] {
    ST_OK      = 3'd0,
    ST_TIMEOUT = 3'd1,
    ST_FAULT   = 3'd2,
    ST_BADACK  = 3'd3,
    ST_PARITY  = 3'd4,
    ST_SKIPPED = 3'd5,
    ST_SEQ     = 3'd6
  } status_t;

  typedef enum logic [1:0] {
    PH_IDLE = 2'd0,
    PH_ACK  = 2'd1,
    PH_READ = 2'd2
  } phase_t;

  typedef enum logic [1:0] {
    AK_OK    = 2'd0,
    AK_WAIT  = 2'd1,
    AK_FAULT = 2'd2,
    AK_BAD   = 2'd3
  } ack_cls_t;

  typedef struct packed {
    logic [1:0]  cmd;
    logic        ap_not_dp;
    logic        read_not_write;
    logic [3:0]  reg_addr;
    logic [31:0] write_data;
    logic [2:0]  ack_bits;
    logic [31:0] read_word;
    logic        read_parity;
  } in_t;

  typedef struct packed {
    logic        send_request;
    logic [7:0]  request_byte;
    logic        send_write;
    logic [31:0] write_word;
    logic        write_parity;
    logic        send_idle;
    logic        done_res;
    logic [2:0]  status;
    logic [31:0] value;
  } out_t;

  typedef struct packed {
    cmd_t        cmd;
    logic        ap;
    logic        rd;
    logic [7:0]  req;
    logic [31:0] wword;
    logic        wpar;
    ack_cls_t    ack;
    logic [31:0] rword;
    logic        rerr;
  } dec_t;

  function automatic logic [7:0] build_request(input logic ap, input logic rd,
                                               input logic [3:0] addr);
    logic [7:0] req;
    logic [3:0] a;
    req = REQ_BASE;
    a   = addr & ADDR_MASK;
    if (ap) req = req ^ REQ_AP_FLIP;
    if (rd) req = req ^ REQ_RD_FLIP;
    req = req | {3'b000, a[3:2], 3'b000};
    if (a == ADDR_4 || a == ADDR_8) req = req ^ REQ_PAR_FLIP;
    return req;
  endfunction

endpackage

// ===== sv/swd_host_access_sequencer.sv =====
// Top level of the SWD host access sequencer.
// Each request is one transaction-level event of an SWD access (start, ack seen, read data
// seen, clear sticky fault). The block takes one request per clock while the decode queue is
// not full and returns at most one result per request; a taken request is written into the
// two-entry decode queue, and the back-end state update loads the result register when it
// pops the item from the queue.
// The sustained rate of one request per cycle is set by the back-end state
// update; it holds while out_ready stays high, and the queue absorbs stalls on either side.
// Configuration writes are taken at any time and apply from the next cycle.
module swd_host_access_sequencer (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  swdseq_pkg::in_t                     in_data,
  output logic                                out_valid,
  input  logic                                out_ready,
  output swdseq_pkg::out_t                    out_data,
  input  logic                                cfg_we,
  input  logic [swdseq_pkg::CFG_IDX_W-1:0]    cfg_idx,
  input  logic [swdseq_pkg::CFG_DATA_W-1:0]   cfg_wdata
);

  logic             q_full;
  logic             q_push;
  swdseq_pkg::dec_t q_wdata;
  logic             q_pop;
  logic             q_valid;
  swdseq_pkg::dec_t q_rdata;

  swdseq_front u_front (
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .q_full   (q_full),
    .q_push   (q_push),
    .q_wdata  (q_wdata)
  );

  swdseq_fifo u_fifo (
    .clk    (clk),
    .rst_n  (rst_n),
    .push   (q_push),
    .wdata  (q_wdata),
    .full   (q_full),
    .pop    (q_pop),
    .rvalid (q_valid),
    .rdata  (q_rdata)
  );

  swdseq_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_idx),
    .cfg_wdata (cfg_wdata),
    .q_valid   (q_valid),
    .q_rdata   (q_rdata),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

// ===== sv/swdseq_front.sv =====
// Front end: accepts requests and classifies them into decoded items.
module swdseq_front (
  input  logic               in_valid,
  output logic               in_ready,
  input  swdseq_pkg::in_t    in_data,
  input  logic               q_full,
  output logic               q_push,
  output swdseq_pkg::dec_t   q_wdata
);

  always_comb begin
    q_wdata       = '0;
    q_wdata.cmd   = swdseq_pkg::cmd_t'(in_data.cmd);
    q_wdata.ap    = in_data.ap_not_dp;
    q_wdata.rd    = in_data.read_not_write;
    q_wdata.req   = swdseq_pkg::build_request(in_data.ap_not_dp, in_data.read_not_write,
                                              in_data.reg_addr);
    q_wdata.wword = in_data.write_data;
    q_wdata.wpar  = ^in_data.write_data;
    q_wdata.rword = in_data.read_word;
    q_wdata.rerr  = (^in_data.read_word) ^ in_data.read_parity;
    case (in_data.ack_bits)
      swdseq_pkg::ACK_OK:    q_wdata.ack = swdseq_pkg::AK_OK;
      swdseq_pkg::ACK_WAIT:  q_wdata.ack = swdseq_pkg::AK_WAIT;
      swdseq_pkg::ACK_FAULT: q_wdata.ack = swdseq_pkg::AK_FAULT;
      default:               q_wdata.ack = swdseq_pkg::AK_BAD;
    endcase
  end

  assign in_ready = !q_full;
  assign q_push   = in_valid && !q_full;

endmodule

// ===== sv/swdseq_fifo.sv =====
// Two-entry queue of decoded items between the front and back ends.
module swdseq_fifo (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  swdseq_pkg::dec_t wdata,
  output logic             full,
  input  logic             pop,
  output logic             rvalid,
  output swdseq_pkg::dec_t rdata
);

  swdseq_pkg::dec_t mem_r [2];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] count_r, count_nxt;
  logic       do_pop;

  assign full   = (count_r == 2'd2);
  assign rvalid = (count_r != 2'd0);
  assign rdata  = mem_r[rd_ptr_r];
  assign do_pop = pop && rvalid;

  always_comb begin
    wr_ptr_nxt = push   ? !wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = do_pop ? !rd_ptr_r : rd_ptr_r;
    count_nxt  = count_r + {1'b0, push} - {1'b0, do_pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= wdata;
    end
  end

endmodule

// ===== sv/swdseq_back.sv =====
// Back end: access state machine, configuration registers and result register.
module swdseq_back (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_we,
  input  logic [swdseq_pkg::CFG_IDX_W-1:0]    cfg_idx,
  input  logic [swdseq_pkg::CFG_DATA_W-1:0]   cfg_wdata,
  input  logic                                q_valid,
  input  swdseq_pkg::dec_t                    q_rdata,
  output logic                                q_pop,
  output logic                                out_valid,
  input  logic                                out_ready,
  output swdseq_pkg::out_t                    out_data
);

  logic                               allow_timeout_r;
  logic [swdseq_pkg::TRIES_W-1:0]     max_tries_r;
  swdseq_pkg::phase_t                 phase_r, phase_nxt;
  logic                               sticky_r, sticky_nxt;
  logic [7:0]                         held_req_r, held_req_nxt;
  logic                               held_rd_r, held_rd_nxt;
  logic [31:0]                        held_wword_r, held_wword_nxt;
  logic                               held_wpar_r, held_wpar_nxt;
  logic [swdseq_pkg::TRIES_W-1:0]     tries_r, tries_nxt;
  logic                               out_valid_r, out_valid_nxt;
  swdseq_pkg::out_t                   out_r, res;
  logic                               has_res;
  logic                               adv;

  assign adv       = !out_valid_r || out_ready;
  assign q_pop     = q_valid && adv;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  always_comb begin
    phase_nxt = phase_r;
    if (q_pop) begin
      case (q_rdata.cmd)
        swdseq_pkg::CMD_START: begin
          if (phase_r == swdseq_pkg::PH_IDLE && !(q_rdata.ap && sticky_r)) begin
            phase_nxt = swdseq_pkg::PH_ACK;
          end
        end
        swdseq_pkg::CMD_ACK: begin
          if (phase_r == swdseq_pkg::PH_ACK) begin
            if (q_rdata.ack == swdseq_pkg::AK_WAIT && tries_r != '0) begin
              phase_nxt = swdseq_pkg::PH_ACK;
            end else if (q_rdata.ack == swdseq_pkg::AK_OK && held_rd_r) begin
              phase_nxt = swdseq_pkg::PH_READ;
            end else begin
              phase_nxt = swdseq_pkg::PH_IDLE;
            end
          end
        end
        swdseq_pkg::CMD_RDATA: begin
          if (phase_r == swdseq_pkg::PH_READ) begin
            phase_nxt = swdseq_pkg::PH_IDLE;
          end
        end
        default: phase_nxt = phase_r;
      endcase
    end
  end

  always_comb begin
    sticky_nxt     = sticky_r;
    held_req_nxt   = held_req_r;
    held_rd_nxt    = held_rd_r;
    held_wword_nxt = held_wword_r;
    held_wpar_nxt  = held_wpar_r;
    tries_nxt      = tries_r;
    res            = '0;
    has_res        = 1'b0;
    if (q_pop) begin
      case (q_rdata.cmd)
        swdseq_pkg::CMD_CLEAR: begin
          sticky_nxt = 1'b0;
        end
        swdseq_pkg::CMD_START: begin
          has_res = 1'b1;
          if (phase_r != swdseq_pkg::PH_IDLE) begin
            res.done_res = 1'b1;
            res.status   = swdseq_pkg::ST_SEQ;
          end else if (q_rdata.ap && sticky_r) begin
            res.done_res = 1'b1;
            res.status   = swdseq_pkg::ST_SKIPPED;
          end else begin
            held_req_nxt     = q_rdata.req;
            held_rd_nxt      = q_rdata.rd;
            held_wword_nxt   = q_rdata.wword;
            held_wpar_nxt    = q_rdata.wpar;
            tries_nxt        = (max_tries_r == '0) ? '0 : max_tries_r - 1'b1;
            res.send_request = 1'b1;
            res.request_byte = q_rdata.req;
          end
        end
        swdseq_pkg::CMD_ACK: begin
          has_res = 1'b1;
          if (phase_r != swdseq_pkg::PH_ACK) begin
            res.done_res = 1'b1;
            res.status   = swdseq_pkg::ST_SEQ;
          end else begin
            case (q_rdata.ack)
              swdseq_pkg::AK_WAIT: begin
                if (tries_r != '0) begin
                  tries_nxt        = tries_r - 1'b1;
                  res.send_request = 1'b1;
                  res.request_byte = held_req_r;
                end else begin
                  res.done_res = 1'b1;
                  res.status   = allow_timeout_r ? swdseq_pkg::ST_TIMEOUT
                                                 : swdseq_pkg::ST_BADACK;
                end
              end
              swdseq_pkg::AK_FAULT: begin
                sticky_nxt   = 1'b1;
                res.done_res = 1'b1;
                res.status   = swdseq_pkg::ST_FAULT;
              end
              swdseq_pkg::AK_OK: begin
                if (held_rd_r) begin
                  has_res = 1'b0;
                end else begin
                  res.send_write   = 1'b1;
                  res.write_word   = held_wword_r;
                  res.write_parity = held_wpar_r;
                  res.send_idle    = 1'b1;
                  res.done_res     = 1'b1;
                  res.status       = swdseq_pkg::ST_OK;
                end
              end
              default: begin
                res.done_res = 1'b1;
                res.status   = swdseq_pkg::ST_BADACK;
              end
            endcase
          end
        end
        swdseq_pkg::CMD_RDATA: begin
          has_res      = 1'b1;
          res.done_res = 1'b1;
          if (phase_r != swdseq_pkg::PH_READ) begin
            res.status = swdseq_pkg::ST_SEQ;
          end else if (q_rdata.rerr) begin
            res.status = swdseq_pkg::ST_PARITY;
          end else begin
            res.send_idle = 1'b1;
            res.status    = swdseq_pkg::ST_OK;
            res.value     = q_rdata.rword;
          end
        end
        default: has_res = 1'b0;
      endcase
    end
    if (q_pop && has_res) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      allow_timeout_r <= 1'b0;
      max_tries_r     <= swdseq_pkg::MAX_TRIES_RESET;
      phase_r         <= swdseq_pkg::PH_IDLE;
      sticky_r        <= 1'b0;
      held_rd_r       <= 1'b0;
      tries_r         <= '0;
      out_valid_r     <= 1'b0;
    end else begin
      if (cfg_we && cfg_idx == swdseq_pkg::CFG_ALLOW_TIMEOUT) begin
        allow_timeout_r <= cfg_wdata[0];
      end
      if (cfg_we && cfg_idx == swdseq_pkg::CFG_MAX_TRIES) begin
        max_tries_r <= cfg_wdata[swdseq_pkg::TRIES_W-1:0];
      end
      phase_r     <= phase_nxt;
      sticky_r    <= sticky_nxt;
      held_rd_r   <= held_rd_nxt;
      tries_r     <= tries_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    held_req_r   <= held_req_nxt;
    held_wword_r <= held_wword_nxt;
    held_wpar_r  <= held_wpar_nxt;
    if (q_pop && has_res) begin
      out_r <= res;
    end
  end

endmodule
